// File: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Types and widths shared by the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 14;
  localparam int NormBits  = FracBits + 2;
  localparam int EdgeBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * EdgeBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int MagBits   = CrossBits - 1;
  localparam int SqBits    = 2 * MagBits;
  localparam int SumBits   = SqBits + 2;
  localparam int WideBits  = SumBits + 2 * FracBits + 5;
  localparam int NumCells  = FracBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [NormBits-1:0]  norm_t;
  typedef logic signed [WideBits-1:0]  wide_t;
  typedef logic [FracBits:0]           quo_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
  } in_word_t;

  typedef struct packed {
    norm_t normal_x;
    norm_t normal_y;
    norm_t normal_z;
    logic  degenerate;
  } out_word_t;

  // state handed from cell to cell, one lane per component
  typedef struct packed {
    wide_t             s;
    wide_t [2:0]       r;
    wide_t [2:0]       u;
    wide_t [2:0]       v;
    quo_t  [2:0]       q;
    logic  [2:0]       neg;
    logic              degen;
  } cell_word_t;

endpackage

// File: sv/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Edges, cross product, squares and length setup, four pipeline stages.
// ----------------------------------------------------------------------------
module tun_front import tun_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cell_word_t out_data
);

  logic signed [EdgeBits-1:0] e1 [3];
  logic signed [EdgeBits-1:0] e2 [3];

  logic                       v1_r, v2_r, v3_r, v4_r;
  logic                       rdy1, rdy2, rdy3, rdy4;
  logic signed [ProdBits-1:0] p_r   [6];
  logic signed [ProdBits-1:0] p_nxt [6];
  logic [MagBits-1:0]         mag_r   [3];
  logic [MagBits-1:0]         mag_nxt [3];
  logic [2:0]                 neg2_r, neg2_nxt, neg3_r;
  logic [SqBits-1:0]          sq_r   [3];
  logic [SqBits-1:0]          sq_nxt [3];
  cell_word_t                 cw_r, cw_nxt;
  logic signed [CrossBits-1:0] n [3];
  logic [SumBits-1:0]         sum;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    e1[0] = EdgeBits'(in_data.vertex_b_x) - EdgeBits'(in_data.vertex_a_x);
    e1[1] = EdgeBits'(in_data.vertex_b_y) - EdgeBits'(in_data.vertex_a_y);
    e1[2] = EdgeBits'(in_data.vertex_b_z) - EdgeBits'(in_data.vertex_a_z);
    e2[0] = EdgeBits'(in_data.vertex_c_x) - EdgeBits'(in_data.vertex_a_x);
    e2[1] = EdgeBits'(in_data.vertex_c_y) - EdgeBits'(in_data.vertex_a_y);
    e2[2] = EdgeBits'(in_data.vertex_c_z) - EdgeBits'(in_data.vertex_a_z);
    p_nxt[0] = e1[1] * e2[2];
    p_nxt[1] = e1[2] * e2[1];
    p_nxt[2] = e1[2] * e2[0];
    p_nxt[3] = e1[0] * e2[2];
    p_nxt[4] = e1[0] * e2[1];
    p_nxt[5] = e1[1] * e2[0];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n[k]        = CrossBits'(p_r[2*k]) - CrossBits'(p_r[2*k+1]);
      neg2_nxt[k] = n[k][CrossBits-1];
      mag_nxt[k]  = neg2_nxt[k] ? MagBits'(-n[k]) : MagBits'(n[k]);
      sq_nxt[k]   = SqBits'(mag_r[k]) * SqBits'(mag_r[k]);
    end
  end

  always_comb begin
    sum = SumBits'(sq_r[0]) + SumBits'(sq_r[1]) + SumBits'(sq_r[2]);
    cw_nxt.s     = WideBits'(sum);
    cw_nxt.degen = (sum == '0);
    cw_nxt.neg   = neg3_r;
    for (int k = 0; k < 3; k++) begin
      cw_nxt.r[k] = WideBits'(sq_r[k]) <<< (2 * FracBits + 2);
      cw_nxt.u[k] = WideBits'(sum);
      cw_nxt.v[k] = -WideBits'(sum);
      cw_nxt.q[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) p_r <= p_nxt;
    if (rdy2) begin
      mag_r  <= mag_nxt;
      neg2_r <= neg2_nxt;
    end
    if (rdy3) begin
      sq_r   <= sq_nxt;
      neg3_r <= neg2_r;
    end
    if (rdy4) cw_r <= cw_nxt;
  end

  assign out_valid = v4_r;
  assign out_data  = cw_r;

endmodule

// File: sv/tun_cell.sv
// ----------------------------------------------------------------------------
// tun_cell
// One quotient bit of the three normal components, by exact square compare.
// ----------------------------------------------------------------------------
module tun_cell import tun_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cell_word_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cell_word_t out_data
);

  logic       valid_r;
  cell_word_t data_r, data_nxt;
  wide_t      utry [3];

  assign in_ready = !valid_r || out_ready;

  // (2q-1)^2 s kept in u, (2q-1) s kept in v
  always_comb begin
    data_nxt = in_data;
    for (int k = 0; k < 3; k++) begin
      utry[k] = in_data.u[k] + (in_data.v[k] <<< (BIT + 2))
              + (in_data.s <<< (2 * BIT + 2));
      if (utry[k] <= in_data.r[k]) begin
        data_nxt.u[k]      = utry[k];
        data_nxt.v[k]      = in_data.v[k] + (in_data.s <<< (BIT + 1));
        data_nxt.q[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: sv/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle, Q8.8 vertices in, Q2.14 components out.
// ----------------------------------------------------------------------------
// Input word: the three vertices on in_data, taken when in_valid and
// in_ready are both high. Output word: normal_x/y/z and degenerate on
// out_data, taken when out_valid and out_ready are both high.
// Every input word gives exactly one output word, in order.
// A word passes through four setup stages (edges and products, cross
// product, squares, length sum), one cell per quotient bit (15 cells,
// each doing one exact square compare per lane), and the output register.
// Throughput is one word per cycle while out_ready stays high; each stage holds one word.
// When out_ready is low, words pile up stage by stage and in_ready drops
// only once every stage is full, so bubbles are squeezed out.
// A zero cross product gives zero components with degenerate set.
// Reset clears all valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  cell_word_t        cw   [NumCells+1];
  logic [NumCells:0] cv;
  logic [NumCells:0] cr;
  logic              out_valid_r;
  logic              fin_ready;
  out_word_t         word_r, word_nxt;
  norm_t             nv [3];

  tun_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cw[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    tun_cell #(.BIT(FracBits - i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cw[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cw[i+1])
    );
  end

  assign fin_ready    = !out_valid_r || out_ready;
  assign cr[NumCells] = fin_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nv[k] = cw[NumCells].neg[k] ? -NormBits'(cw[NumCells].q[k])
                                  : NormBits'(cw[NumCells].q[k]);
      if (cw[NumCells].degen) nv[k] = '0;
    end
    word_nxt.normal_x   = nv[0];
    word_nxt.normal_y   = nv[1];
    word_nxt.normal_z   = nv[2];
    word_nxt.degenerate = cw[NumCells].degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= cv[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready) word_r <= word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = word_r;

  localparam norm_t OneVal = norm_t'(1) <<< FracBits;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate word with nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x <= OneVal && out_data.normal_x >= -OneVal &&
                  out_data.normal_y <= OneVal && out_data.normal_y >= -OneVal &&
                  out_data.normal_z <= OneVal && out_data.normal_z >= -OneVal)
    else $error("normal component beyond unit range");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0)
    else $error("nondegenerate word with zero normal");

endmodule

// File: tb/sv/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// Self-checking bench for the triangle unit normal pipeline. Triangles are
// queued up front (directed corners, then random), driven with random gaps,
// and every output word is checked against an exact integer model of the
// rounded unit normal. Backpressure comes in random bursts, plus one long
// hold-off that fills the pipe and one sender pause that drains it.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal import tun_pkg::*; ();

  localparam int  NumRandom  = 1530;
  localparam int  TailItems  = 200;
  localparam int  HoldAt     = 300;
  localparam int  HoldCycles = 80;
  localparam int  PauseAt    = 800;
  localparam longint Limit   = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  in_word_t  pending_tris[$];
  out_word_t expected_normals[$];
  int        sent_count = 0;
  int        recv_count = 0;
  int        error_count = 0;
  int        send_gap = 0;
  int        recv_stall = 0;
  bit        paused_once = 1'b0;
  bit        held_once = 1'b0;
  longint    cycle_count = 0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // exact rounded |N| quotient: largest q with (2q-1)^2 * s <= 4 m^2 2^(2F)
  function automatic norm_t unit_component(longint n, logic [127:0] s);
    logic [127:0] m, rhs, t;
    logic [FracBits:0] q, cand;
    m = 128'((n < 0) ? -n : n);
    rhs = (m * m) << (2 * FracBits + 2);
    q = '0;
    for (int b = FracBits; b >= 0; b--) begin
      cand = q;
      cand[b] = 1'b1;
      t = (128'(cand) << 1) - 128'(1);
      if (t * t * s <= rhs) q = cand;
    end
    return (n < 0) ? -norm_t'(q) : norm_t'(q);
  endfunction

  function automatic out_word_t face_normal(in_word_t w);
    longint e1[3], e2[3], n[3];
    logic [127:0] s;
    out_word_t r;
    e1[0] = longint'(w.vertex_b_x) - longint'(w.vertex_a_x);
    e1[1] = longint'(w.vertex_b_y) - longint'(w.vertex_a_y);
    e1[2] = longint'(w.vertex_b_z) - longint'(w.vertex_a_z);
    e2[0] = longint'(w.vertex_c_x) - longint'(w.vertex_a_x);
    e2[1] = longint'(w.vertex_c_y) - longint'(w.vertex_a_y);
    e2[2] = longint'(w.vertex_c_z) - longint'(w.vertex_a_z);
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      s += 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(n[i] < 0 ? -n[i] : n[i]);
    end
    r = '0;
    if (s == 0) begin
      r.degenerate = 1'b1;
    end else begin
      r.normal_x = unit_component(n[0], s);
      r.normal_y = unit_component(n[1], s);
      r.normal_z = unit_component(n[2], s);
    end
    return r;
  endfunction

  function automatic in_word_t tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
    in_word_t w;
    w.vertex_a_x = coord_t'(ax); w.vertex_a_y = coord_t'(ay); w.vertex_a_z = coord_t'(az);
    w.vertex_b_x = coord_t'(bx); w.vertex_b_y = coord_t'(by); w.vertex_b_z = coord_t'(bz);
    w.vertex_c_x = coord_t'(cx); w.vertex_c_y = coord_t'(cy); w.vertex_c_z = coord_t'(cz);
    return w;
  endfunction

  function automatic int rand_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic add_tri(in_word_t w);
    pending_tris = {pending_tris, w};
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_normals = {expected_normals, face_normal(in_data)};
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!paused_once && sent_count >= PauseAt) begin
          in_valid <= 1'b0;
          if (expected_normals.size() == 0 && !(in_valid && in_ready)) paused_once <= 1'b1;
        end else if (pending_tris.size() > 0) begin
          in_data  <= pending_tris.pop_front();
          in_valid <= 1'b1;
          if (pending_tris.size() > TailItems && $urandom_range(7) == 0)
            send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!held_once && recv_count >= HoldAt) begin
        held_once = 1'b1;
        recv_stall = HoldCycles;
      end else if (recv_stall == 0 && pending_tris.size() > TailItems
                   && $urandom_range(7) == 0) begin
        recv_stall = $urandom_range(1, 15);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      recv_count++;
      if (expected_normals.size() == 0) begin
        $error("unexpected output word %h", out_data);
        error_count++;
      end else begin
        want = expected_normals.pop_front();
        if (out_data.normal_x !== want.normal_x) begin
          $error("normal_x: expected %0d, got %0d", want.normal_x, out_data.normal_x);
          error_count++;
        end
        if (out_data.normal_y !== want.normal_y) begin
          $error("normal_y: expected %0d, got %0d", want.normal_y, out_data.normal_y);
          error_count++;
        end
        if (out_data.normal_z !== want.normal_z) begin
          $error("normal_z: expected %0d, got %0d", want.normal_z, out_data.normal_z);
          error_count++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, out_data.degenerate);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > Limit) begin
      $display("tb_triangle_unit_normal: errors");
      $finish;
    end
  end

  initial begin
    int ax, ay, az, dx, dy, dz, k;
    // all zero, all equal: degenerate
    add_tri(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_tri(tri_of(-32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, -32768, -32768));
    // collinear, then a nearly collinear triangle in the y = 0 plane
    add_tri(tri_of(0, 0, 0, 256, 256, 256, 512, 512, 512));
    add_tri(tri_of(-32768, 0, 32767, 32767, 0, -32768, 0, 0, 0));
    // axis-aligned, both signs
    add_tri(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0));
    add_tri(tri_of(0, 0, 0, 0, 256, 0, 256, 0, 0));
    add_tri(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256));
    add_tri(tri_of(0, 0, 0, 0, 0, 256, 0, 256, 0));
    add_tri(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0));
    add_tri(tri_of(0, 0, 0, 256, 0, 0, 0, 0, 256));
    // extreme edges
    add_tri(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                   -32768, 32767, -32768));
    add_tri(tri_of(32767, 32767, 32767, -32768, 32767, 32767,
                   32767, -32768, 32767));
    add_tri(tri_of(-32768, -32768, -32768, 32767, 32767, -32768,
                   -32768, 32767, 32767));
    add_tri(tri_of(32767, -32768, 32767, -32768, 32767, -32768,
                   32767, 32767, -32768));
    // tiny triangle, diagonal normal, ties near rounding
    add_tri(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
    add_tri(tri_of(0, 0, 0, 1, -1, 0, 0, 1, -1));
    add_tri(tri_of(5, 7, -3, 6, 7, -2, 5, 8, -3));
    add_tri(tri_of(-1, -1, -1, -1, 0, -1, 0, -1, 0));
    for (int i = 0; i < NumRandom; i++) begin
      k = $urandom_range(9);
      if (k < 5) begin
        add_tri(tri_of(rand_coord(32768), rand_coord(32768),
          rand_coord(32768), rand_coord(32768), rand_coord(32768), rand_coord(32768),
          rand_coord(32768), rand_coord(32768), rand_coord(32768)));
      end else if (k < 8) begin
        ax = rand_coord(30000); ay = rand_coord(30000); az = rand_coord(30000);
        add_tri(tri_of(ax, ay, az,
          ax + rand_coord(8), ay + rand_coord(8), az + rand_coord(8),
          ax + rand_coord(8), ay + rand_coord(8), az + rand_coord(8)));
      end else begin
        // collinear: C = A + k (B - A)
        ax = rand_coord(1000); ay = rand_coord(1000); az = rand_coord(1000);
        dx = rand_coord(300); dy = rand_coord(300); dz = rand_coord(300);
        k = $urandom_range(6) - 3;
        add_tri(tri_of(ax, ay, az, ax + dx, ay + dy, az + dz,
                       ax + k * dx, ay + k * dy, az + k * dz));
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_tris.size() == 0);
    @(posedge clk iff !in_valid);
    wait (expected_normals.size() == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_normals.size() == 0) begin
      $display("tb_triangle_unit_normal: clean");
    end else begin
      $display("tb_triangle_unit_normal: errors");
    end
    $finish;
  end

endmodule

// File: triangle_unit_normal.f
sv/tun_pkg.sv
sv/tun_front.sv
sv/tun_cell.sv
sv/triangle_unit_normal.sv
tb/sv/tb_triangle_unit_normal.sv
